### rtl/core/vnsl_pkg.sv
// Shared types and constants for the nearest-site labeling block.
// No dependencies; every other file in rtl/core imports this package.
package vnsl_pkg;

    // Fixed field widths of the request and response beats
    localparam int COORD_W    = 7;
    localparam int SITE_IDX_W = 6;
    localparam int VAL_W      = 4;
    localparam int DIST_OUT_W = 15;
    localparam int CFG_W      = 7;

    // Reset value of the sites-in-use register
    localparam logic [CFG_W-1:0] SITES_IN_USE_RST = 7'd50;

    // Request kind
    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req_kind;

    // Beat as it travels down the cell chain (distance travels beside it)
    typedef struct packed {
        logic                  valid;
        t_req_kind             kind;
        logic [SITE_IDX_W-1:0] site_index;
        logic [COORD_W-1:0]    pos_x;
        logic [COORD_W-1:0]    pos_y;
        logic [VAL_W-1:0]      site_value;
        logic [SITE_IDX_W-1:0] best_idx;
        logic [VAL_W-1:0]      best_val;
    } t_beat;

endpackage

### rtl/core/vnsl_req_if.sv
// Request channel: load a site or query a pixel.
// Depends on vnsl_pkg.
interface vnsl_req_if import vnsl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_req_kind             req_type;
    logic [SITE_IDX_W-1:0] site_index;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [VAL_W-1:0]      site_value;

    modport source (output valid, req_type, site_index, pos_x, pos_y, site_value,
                    input ready);
    modport sink   (input valid, req_type, site_index, pos_x, pos_y, site_value,
                    output ready);
endinterface

### rtl/core/vnsl_rsp_if.sv
// Response channel: label, index and squared distance of the nearest site.
// Depends on vnsl_pkg.
interface vnsl_rsp_if import vnsl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VAL_W-1:0]      region_value;
    logic [SITE_IDX_W-1:0] nearest_site;
    logic [DIST_OUT_W-1:0] nearest_distance;

    modport source (output valid, region_value, nearest_site, nearest_distance,
                    input ready);
    modport sink   (input valid, region_value, nearest_site, nearest_distance,
                    output ready);
endinterface

### rtl/core/vnsl_cell.sv
// One chain cell: holds a single site and compares a passing query against it.
// Depends on vnsl_pkg.
module vnsl_cell import vnsl_pkg::*; #(
    parameter int IDX    = 0,
    parameter int DIST_W = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [CFG_W-1:0]  i_count,
    input  t_beat             i_beat,
    input  logic [DIST_W-1:0] i_dist,
    output t_beat             o_beat,
    output logic [DIST_W-1:0] o_dist
);

    logic [COORD_W-1:0]   r_site_x;
    logic [COORD_W-1:0]   r_site_y;
    logic [VAL_W-1:0]     r_site_val;
    t_beat                r_beat;
    logic [DIST_W-1:0]    r_dist;

    logic [COORD_W:0]     w_dx_raw;
    logic [COORD_W:0]     w_dy_raw;
    logic [COORD_W-1:0]   w_dx;
    logic [COORD_W-1:0]   w_dy;
    logic [2*COORD_W-1:0] w_dx2;
    logic [2*COORD_W-1:0] w_dy2;
    logic [2*COORD_W:0]   w_d;
    logic                 w_in_use;
    logic                 w_win;
    logic                 w_load_hit;
    t_beat                n_beat;
    logic [DIST_W-1:0]    n_dist;

    // Squared distance from the beat's pixel to this site
    always_comb begin
        w_dx_raw = {1'b0, i_beat.pos_x} - {1'b0, r_site_x};
        w_dy_raw = {1'b0, i_beat.pos_y} - {1'b0, r_site_y};
        w_dx     = w_dx_raw[COORD_W] ? COORD_W'(-w_dx_raw) : w_dx_raw[COORD_W-1:0];
        w_dy     = w_dy_raw[COORD_W] ? COORD_W'(-w_dy_raw) : w_dy_raw[COORD_W-1:0];
        w_dx2    = w_dx * w_dx;
        w_dy2    = w_dy * w_dy;
        w_d      = {1'b0, w_dx2} + {1'b0, w_dy2};
    end

    // Strictly closer wins, so ties keep the earlier cell
    always_comb begin
        w_in_use   = (IDX < int'(i_count));
        w_win      = i_beat.valid && (i_beat.kind == REQ_QUERY) && w_in_use &&
                     (DIST_W'(w_d) < i_dist);
        w_load_hit = i_adv && i_beat.valid && (i_beat.kind == REQ_LOAD) &&
                     (int'(i_beat.site_index) == IDX);

        n_beat = i_beat;
        n_dist = i_dist;
        if (w_win) begin
            n_beat.best_idx = SITE_IDX_W'(IDX);
            n_dist          = DIST_W'(w_d);
        end
        // site 0 supplies the label when nobody beats the start distance
        if (w_win || (IDX == 0)) begin
            n_beat.best_val = r_site_val;
        end
    end

    // Site storage, written when a load beat for this slot passes
    always_ff @(posedge i_clk) begin
        if (w_load_hit) begin
            r_site_x   <= i_beat.pos_x;
            r_site_y   <= i_beat.pos_y;
            r_site_val <= i_beat.site_value;
        end
    end

    // Stage register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_adv) begin
            r_beat <= n_beat;
            r_dist <= n_dist;
        end
    end

    assign o_beat = r_beat;
    assign o_dist = r_dist;

endmodule

### rtl/core/voronoi_nearest_site_label.sv
// Top level of the nearest-site labeling block: a chain of site cells and
// an output register. Depends on vnsl_pkg, vnsl_req_if, vnsl_rsp_if, vnsl_cell.
//
//   channel   dir   payload                                           
//   i_req     in    req_type, site_index, pos_x, pos_y, site_value   
//   o_rsp     out   region_value, nearest_site, nearest_distance     
//   i_cfg_*   in    sites_in_use (7 bits), write only                
//
// One beat enters per cycle unless o_rsp stalls; each beat walks MAX_SITES cells, one per
// cycle while not stalled, and the output register after the last cell presents a query's result.
// Loads travel the same chain and are dropped at the end, giving no result.
// A stall on o_rsp freezes the whole chain and holds i_req.ready low.
// Reset clears the valid bits and sets sites_in_use to 50; stored sites are
// undefined until loaded.
module voronoi_nearest_site_label import vnsl_pkg::*; #(
    parameter int MAX_SITES = 64,
    parameter int GRID_SIZE = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    vnsl_req_if.sink         i_req,
    vnsl_rsp_if.source       o_rsp
);

    localparam int GRID_SQ = GRID_SIZE * GRID_SIZE;
    localparam int DIST_LOG = $clog2(GRID_SQ + 1);
    localparam int DIST_W = (DIST_LOG > DIST_OUT_W) ? DIST_LOG : DIST_OUT_W;

    logic [CFG_W-1:0]      r_sites_in_use;
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_out_val;
    logic [SITE_IDX_W-1:0] r_out_idx;
    logic [DIST_W-1:0]     r_out_dist;
    logic                  w_adv;
    t_beat                 w_beat [0:MAX_SITES];
    logic [DIST_W-1:0]     w_dist [0:MAX_SITES];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites_in_use <= SITES_IN_USE_RST;
        end else if (i_cfg_we) begin
            r_sites_in_use <= i_cfg_wdata;
        end
    end

    // Chain moves whenever the output register is free or being drained
    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    // Head of the chain: best so far is site 0 at the start distance
    always_comb begin
        w_beat[0].valid      = i_req.valid;
        w_beat[0].kind       = i_req.req_type;
        w_beat[0].site_index = i_req.site_index;
        w_beat[0].pos_x      = i_req.pos_x;
        w_beat[0].pos_y      = i_req.pos_y;
        w_beat[0].site_value = i_req.site_value;
        w_beat[0].best_idx   = '0;
        w_beat[0].best_val   = '0;
        w_dist[0]            = DIST_W'(GRID_SQ);
    end

    // Row of site cells
    for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
        vnsl_cell #(
            .IDX    (g),
            .DIST_W (DIST_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_count (r_sites_in_use),
            .i_beat  (w_beat[g]),
            .i_dist  (w_dist[g]),
            .o_beat  (w_beat[g+1]),
            .o_dist  (w_dist[g+1])
        );
    end

    // Output register: only query beats become results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_beat[MAX_SITES].valid &&
                           (w_beat[MAX_SITES].kind == REQ_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_val  <= w_beat[MAX_SITES].best_val;
            r_out_idx  <= w_beat[MAX_SITES].best_idx;
            r_out_dist <= w_dist[MAX_SITES];
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.region_value     = r_out_val;
    assign o_rsp.nearest_site     = r_out_idx;
    assign o_rsp.nearest_distance = r_out_dist[DIST_OUT_W-1:0];

    // A held result must back-pressure the request side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request accepted while result is stalled");

    // Distance never exceeds the start value
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dist <= DIST_W'(GRID_SQ)))
        else $error("nearest distance above grid size squared");

    // No closer site found means site 0 is reported
    a_default_site: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_dist == DIST_W'(GRID_SQ))) |-> (r_out_idx == '0))
        else $error("start distance reported with nonzero site");

    // Configuration write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_sites_in_use == $past(i_cfg_wdata)))
        else $error("sites_in_use write lost");

endmodule
